// File: rtl/modexp_pkg.sv
// Shared constants for the modular exponentiation block.
`default_nettype none

package modexp_pkg;

   // Base field width, fixed by the stream format.
   localparam int BASE_WIDTH = 63;

   // Bit counter of the serial multiplier; it holds up to BASE_WIDTH.
   localparam int CNT_WIDTH = $clog2(BASE_WIDTH + 1);

   // Modulus after reset.
   localparam logic [31:0] MODULUS_RESET = 32'd1000000007;

endpackage : modexp_pkg

`default_nettype wire

// File: rtl/modexp_mulmod.sv
// Bit-serial interleaved modular multiplier: a * b mod m, one multiplier bit at a time, each as a double then an add.
`default_nettype none

module modexp_mulmod #(
   parameter int MOD_WIDTH = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic [MOD_WIDTH-1:0]                 mcand,
   input  logic [modexp_pkg::BASE_WIDTH-1:0]    mplier,   // scanned from the top bit
   input  logic [modexp_pkg::CNT_WIDTH-1:0]     nbits,
   input  logic [MOD_WIDTH-1:0]                 modulus,
   output logic                                 busy,
   output logic                                 done,
   output logic [MOD_WIDTH-1:0]                 product
);
   import modexp_pkg::*;

   logic [MOD_WIDTH-1:0]  r_ff, r_in;
   logic [MOD_WIDTH-1:0]  a_ff;
   logic [MOD_WIDTH-1:0]  m_ff;
   logic [BASE_WIDTH-1:0] sh_ff;
   logic [CNT_WIDTH-1:0]  cnt_ff;
   logic                  phase_ff;
   logic                  busy_ff;
   logic                  done_ff;

   logic [MOD_WIDTH:0]    pre;
   logic [MOD_WIDTH:0]    diff;

   // phase 0 doubles, phase 1 adds the multiplicand when the current bit is set
   always_comb begin
      if (!phase_ff) begin
         pre = {r_ff, 1'b0};
      end else begin
         pre = {1'b0, r_ff} + (sh_ff[BASE_WIDTH-1] ? {1'b0, a_ff} : '0);
      end
      diff = pre - {1'b0, m_ff};
      // pre < 2m, so one conditional subtract reduces it
      if (pre >= {1'b0, m_ff}) begin
         r_in = diff[MOD_WIDTH-1:0];
      end else begin
         r_in = pre[MOD_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         phase_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff  <= 1'b1;
            phase_ff <= 1'b0;
            r_ff     <= '0;
            a_ff     <= mcand;
            m_ff     <= modulus;
            sh_ff    <= mplier;
            cnt_ff   <= nbits;
         end else if (busy_ff) begin
            r_ff     <= r_in;
            phase_ff <= ~phase_ff;
            if (phase_ff) begin
               sh_ff  <= {sh_ff[BASE_WIDTH-2:0], 1'b0};
               cnt_ff <= cnt_ff - 1'b1;
               if (cnt_ff == CNT_WIDTH'(1)) begin
                  busy_ff <= 1'b0;
                  done_ff <= 1'b1;
               end
            end
         end
      end
   end

   assign busy    = busy_ff;
   assign done    = done_ff;
   assign product = r_ff;

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff)
      else $error("mulmod: done while busy");

   a_done_reduced: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (m_ff == '0) || (r_ff < m_ff))
      else $error("mulmod: product not reduced");

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && nbits != '0) |=> busy_ff)
      else $error("mulmod: start did not launch");

   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff)
      else $error("mulmod: done longer than one cycle");

endmodule : modexp_mulmod

`default_nettype wire

// File: rtl/modular_exponentiation.sv
// Top level of the modular exponentiation block: sequencer, operand registers, result register.
//
//  channel  dir  handshake              beat contents (low bits first)
//  req      in   req_tvalid/req_tready  base[62:0], exponent[EXP_WIDTH-1:0], zero pad
//  rsp      out  rsp_tvalid/rsp_tready  residue[MOD_WIDTH-1:0], zero pad
//  csr      in   csr_wr_en              modulus[MOD_WIDTH-1:0], no read-back
//
// Flow: one item at a time. Base reduction scans all 63 base bits, then every
//   exponent bit up to the top set bit costs one multiply when set and every bit
//   below the top set bit one squaring, all on the single bit-serial multiplier.
// Reset: synchronous; modulus returns to 1000000007, no item in flight.
// Stalls: req is taken whenever the sequencer is idle, even with a result
//   still waiting on rsp; a finished result waits for the output register.
`default_nettype none

module modular_exponentiation #(
   parameter int MOD_WIDTH = 32,
   parameter int EXP_WIDTH = 63
) (
   input  logic clock,
   input  logic reset,
   // fields low to high: base[62:0], exponent, zero pad
   input  logic [((modexp_pkg::BASE_WIDTH + EXP_WIDTH + 7) / 8) * 8 - 1:0] req_tdata,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // fields low to high: residue, zero pad
   output logic [((MOD_WIDTH + 7) / 8) * 8 - 1:0] rsp_tdata,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   input  logic                                   csr_wr_en,
   input  logic [MOD_WIDTH-1:0]                   csr_wr_data
);
   import modexp_pkg::*;

   localparam int RSP_WIDTH = ((MOD_WIDTH + 7) / 8) * 8;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_CHECK,
      ST_MULACC,
      ST_SQUARE,
      ST_FINISH
   } state_type;

   state_type              state_ff;
   logic [MOD_WIDTH-1:0]   modulus_ff;
   logic [EXP_WIDTH-1:0]   exp_ff;
   logic [MOD_WIDTH-1:0]   acc_ff;
   logic [MOD_WIDTH-1:0]   sq_ff;
   logic                   mm_start_ff;
   logic [MOD_WIDTH-1:0]   op_a_ff;
   logic [BASE_WIDTH-1:0]  op_b_ff;
   logic [CNT_WIDTH-1:0]   nbits_ff;
   logic                   rsp_valid_ff;
   logic [MOD_WIDTH-1:0]   residue_ff;

   logic                   mm_busy;
   logic                   mm_done;
   logic [MOD_WIDTH-1:0]   mm_product;
   logic                   req_beat;
   logic                   rsp_free;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_beat   = req_tvalid && req_tready;
   // output register can take a new result this cycle
   assign rsp_free   = !rsp_valid_ff || rsp_tready;

   // modulus register; the user must write it only between items, the block does not enforce it
   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff <= MODULUS_RESET[MOD_WIDTH-1:0];
      end else if (csr_wr_en) begin
         modulus_ff <= csr_wr_data;
      end
   end

   // sequencer: reduce base, then right-to-left square-and-multiply
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mm_start_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mm_start_ff <= 1'b0;
         if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_beat) begin
                  exp_ff      <= req_tdata[BASE_WIDTH +: EXP_WIDTH];
                  // base mod m as 1 * base, scanning all base bits
                  op_a_ff     <= MOD_WIDTH'(1);
                  op_b_ff     <= req_tdata[BASE_WIDTH-1:0];
                  nbits_ff    <= CNT_WIDTH'(BASE_WIDTH);
                  mm_start_ff <= 1'b1;
                  state_ff    <= ST_REDUCE;
               end
            end
            ST_REDUCE: begin
               if (mm_done) begin
                  sq_ff    <= mm_product;
                  // 1 mod m: zero when the modulus is zero or one
                  acc_ff   <= (modulus_ff > MOD_WIDTH'(1)) ? MOD_WIDTH'(1) : '0;
                  state_ff <= ST_CHECK;
               end
            end
            ST_CHECK: begin
               op_b_ff  <= {sq_ff, {(BASE_WIDTH - MOD_WIDTH){1'b0}}};
               nbits_ff <= CNT_WIDTH'(MOD_WIDTH);
               if (exp_ff == '0) begin
                  state_ff <= ST_FINISH;
               end else if (exp_ff[0]) begin
                  op_a_ff     <= acc_ff;
                  mm_start_ff <= 1'b1;
                  state_ff    <= ST_MULACC;
               end else begin
                  op_a_ff     <= sq_ff;
                  mm_start_ff <= 1'b1;
                  state_ff    <= ST_SQUARE;
               end
            end
            ST_MULACC: begin
               if (mm_done) begin
                  acc_ff <= mm_product;
                  // last set bit: the trailing square is never used
                  if ((exp_ff >> 1) == '0) begin
                     state_ff <= ST_FINISH;
                  end else begin
                     op_a_ff     <= sq_ff;
                     mm_start_ff <= 1'b1;
                     state_ff    <= ST_SQUARE;
                  end
               end
            end
            ST_SQUARE: begin
               if (mm_done) begin
                  sq_ff    <= mm_product;
                  exp_ff   <= exp_ff >> 1;
                  state_ff <= ST_CHECK;
               end
            end
            ST_FINISH: begin
               if (rsp_free) begin
                  // modulus zero has no reduction: residue forced to zero
                  residue_ff   <= (modulus_ff == '0) ? '0 : acc_ff;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   modexp_mulmod #(
      .MOD_WIDTH (MOD_WIDTH)
   ) u_mulmod (
      .clock   (clock),
      .reset   (reset),
      .start   (mm_start_ff),
      .mcand   (op_a_ff),
      .mplier  (op_b_ff),
      .nbits   (nbits_ff),
      .modulus (modulus_ff),
      .busy    (mm_busy),
      .done    (mm_done),
      .product (mm_product)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_WIDTH'(residue_ff);

   a_idle_no_mul: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !mm_busy)
      else $error("modexp: multiplier busy while idle");

   a_start_from_idle: assert property (@(posedge clock) disable iff (reset)
      mm_start_ff |-> !mm_busy)
      else $error("modexp: multiplier restarted while busy");

   a_result_reduced: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> (modulus_ff == '0) || (residue_ff < modulus_ff))
      else $error("modexp: residue not below modulus");

endmodule : modular_exponentiation

`default_nettype wire
